FILE: rtl/controller_port_read_mux_top_assert.svh
`ifndef CONTROLLER_PORT_READ_MUX_TOP_ASSERT_SVH
`define CONTROLLER_PORT_READ_MUX_TOP_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define CPRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cprm assertion failed");

// Checks that a condition holds in the cycle after its trigger.
`define CPRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cprm assertion failed");

`endif

FILE: rtl/cprm_pkg.sv
package cprm_pkg;

  localparam logic [2:0] DEV_JOYPAD   = 3'd0;
  localparam logic [2:0] DEV_GUN      = 3'd1;
  localparam logic [2:0] DEV_PADDLE   = 3'd2;
  localparam logic [2:0] DEV_SPORTPAD = 3'd3;
  localparam logic [2:0] DEV_TABLET   = 3'd4;

  localparam logic [1:0] REG_PLAYER1_DEVICE = 2'd0;
  localparam logic [1:0] REG_PLAYER2_DEVICE = 2'd1;
  localparam logic [1:0] REG_KBD_ATTACHED   = 2'd2;

  localparam logic [7:0] CTL_SP1_HIGH    = 8'h0D;
  localparam logic [7:0] CTL_SP1_LOW     = 8'h2D;
  localparam logic [7:0] CTL_SP2_UPPER   = 8'h07;
  localparam logic [7:0] CTL_SP2_LOWER   = 8'h87;
  localparam logic [7:0] CTL_FLIP_FLOP   = 8'h55;
  localparam logic [7:0] CTL_PADDLE_LOW  = 8'hDD;
  localparam logic [7:0] CTL_PADDLE_HIGH = 8'hFD;

  localparam logic [2:0] KBD_NO_ROW = 3'd7;

  typedef struct packed {
    logic [2:0] player1_device;
    logic [2:0] player2_device;
    logic       kbd_attached;
  } cfg_t;

  typedef struct packed {
    logic first_port;
    logic second_port;
  } toggle_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  row_select;
    logic [15:0] keyboard_word;
    logic [15:0] pad_word;
    logic [7:0]  port_control;
    logic [7:0]  sportpad1_value;
    logic [7:0]  sportpad2_value;
    logic [7:0]  paddle1_position;
    logic [7:0]  paddle2_position;
  } read_req_t;

  function automatic logic is_analog(input logic [2:0] dev);
    return (dev == DEV_PADDLE) || (dev == DEV_SPORTPAD);
  endfunction

endpackage

FILE: rtl/cprm_read_unit.sv
module cprm_read_unit
  import cprm_pkg::*;
(
  input  cfg_t       cfg_i,
  input  toggle_t    toggle_i,
  input  read_req_t  req_i,
  output logic [7:0] read_data_o,
  output toggle_t    toggle_o
);

  logic [7:0] first_v;
  logic [7:0] first_lo;
  logic [7:0] first_hi;
  logic [7:0] second_v;
  logic [7:0] second_lo;
  logic [7:0] second_hi;
  logic       kbd_read;
  toggle_t    flipped;

  assign kbd_read = cfg_i.kbd_attached && (req_i.row_select != KBD_NO_ROW);

  assign flipped = {toggle_i.first_port ^ (cfg_i.player1_device == DEV_PADDLE),
                    toggle_i.second_port ^ (cfg_i.player2_device == DEV_PADDLE)};

  assign first_lo = {req_i.paddle2_position[1:0], 2'b01, req_i.paddle1_position[3:0]};
  assign first_hi = {req_i.paddle2_position[5:4], 2'b01, req_i.paddle1_position[7:4]};
  assign second_lo = {6'h3F, req_i.paddle2_position[3:2]};
  assign second_hi = {6'h3F, req_i.paddle2_position[7:6]};

  always_comb begin
    first_v = req_i.pad_word[7:0];
    if (is_analog(cfg_i.player1_device) || is_analog(cfg_i.player2_device)) begin
      case (req_i.port_control)
        CTL_SP1_HIGH:    first_v = {first_v[7:4], req_i.sportpad1_value[7:4]};
        CTL_SP1_LOW:     first_v = {first_v[7:4], req_i.sportpad1_value[3:0]};
        CTL_SP2_UPPER:   first_v = {req_i.sportpad2_value[5:4], first_v[5:0]};
        CTL_SP2_LOWER:   first_v = {req_i.sportpad2_value[1:0], first_v[5:0]};
        CTL_FLIP_FLOP:   first_v = first_v & (toggle_i.first_port ? first_lo : first_hi);
        CTL_PADDLE_LOW:  first_v = first_v & first_lo;
        CTL_PADDLE_HIGH: first_v = first_v & first_hi;
        default:         first_v = first_v;
      endcase
    end
    if (cfg_i.player1_device == DEV_PADDLE) begin
      first_v[5] = flipped.first_port;
    end
  end

  always_comb begin
    second_v = req_i.pad_word[15:8];
    if (is_analog(cfg_i.player2_device)) begin
      case (req_i.port_control)
        CTL_SP2_UPPER:   second_v = {second_v[7:2], req_i.sportpad2_value[7:6]};
        CTL_SP2_LOWER:   second_v = {second_v[7:2], req_i.sportpad2_value[3:2]};
        CTL_FLIP_FLOP:   second_v = second_v & (toggle_i.second_port ? second_lo : second_hi);
        CTL_PADDLE_LOW:  second_v = second_v & second_lo;
        CTL_PADDLE_HIGH: second_v = second_v & second_hi;
        default:         second_v = second_v;
      endcase
    end
    if (cfg_i.player2_device == DEV_PADDLE) begin
      second_v[3] = flipped.second_port;
    end
  end

  always_comb begin
    toggle_o = toggle_i;
    if (kbd_read) begin
      read_data_o = req_i.mode ? req_i.keyboard_word[15:8] : req_i.keyboard_word[7:0];
    end else if (!req_i.mode) begin
      read_data_o = first_v;
      toggle_o.first_port = flipped.first_port;
    end else begin
      read_data_o = second_v;
      toggle_o.second_port = flipped.second_port;
    end
  end

endmodule

FILE: rtl/controller_port_read_mux_top.sv
// Channel    Direction  Handshake                    Payload
// in         input      in_valid_i / in_stall_o      mode_i .. paddle2_position_i
// out        output     out_valid_o / out_stall_i    read_data_o
// cfg        input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A read transaction passes an input register and then a result register before its result is
// valid; one transaction is accepted per cycle while the input is not stalled.
// The paddle toggle of a port advances only on a non-keyboard read of that port with a paddle
// attached, as the transaction moves into the result register, keeping them in transaction order.
// A stall on the output holds the result register and, once the input register is
// full too, stalls the input. Reset clears the configuration, both toggles and both valid flags.
module controller_port_read_mux_top
  import cprm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [2:0]  row_select_i,
  input  logic [15:0] keyboard_word_i,
  input  logic [15:0] pad_word_i,
  input  logic [7:0]  port_control_i,
  input  logic [7:0]  sportpad1_value_i,
  input  logic [7:0]  sportpad2_value_i,
  input  logic [7:0]  paddle1_position_i,
  input  logic [7:0]  paddle2_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);

  `include "controller_port_read_mux_top_assert.svh"

  cfg_t       cfg_q;
  toggle_t    toggle_q;
  toggle_t    toggle_d;
  logic       s1_valid_q;
  read_req_t  s1_req_q;
  read_req_t  in_req;
  logic       s2_valid_q;
  logic [7:0] s2_data_q;
  logic [7:0] result_d;
  logic       s1_stall;
  logic       s1_adv;
  logic       in_acc;
  logic       kbd_pending;

  assign in_req = '{
    mode:             mode_i,
    row_select:       row_select_i,
    keyboard_word:    keyboard_word_i,
    pad_word:         pad_word_i,
    port_control:     port_control_i,
    sportpad1_value:  sportpad1_value_i,
    sportpad2_value:  sportpad2_value_i,
    paddle1_position: paddle1_position_i,
    paddle2_position: paddle2_position_i
  };

  assign s1_stall   = s2_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !s1_stall;
  assign in_stall_o = s1_valid_q && s1_stall;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = s2_valid_q;
  assign read_data_o = s2_data_q;

  cprm_read_unit u_read (
    .cfg_i       (cfg_q),
    .toggle_i    (toggle_q),
    .req_i       (s1_req_q),
    .read_data_o (result_d),
    .toggle_o    (toggle_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PLAYER1_DEVICE: cfg_q.player1_device <= cfg_data_i;
        REG_PLAYER2_DEVICE: cfg_q.player2_device <= cfg_data_i;
        REG_KBD_ATTACHED:   cfg_q.kbd_attached   <= cfg_data_i[0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      toggle_q   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
        toggle_q   <= toggle_d;
      end else if (s2_valid_q && !out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= in_req;
    end
    if (s1_adv) begin
      s2_data_q <= result_d;
    end
  end

  assign kbd_pending = s1_adv && cfg_q.kbd_attached && (s1_req_q.row_select != KBD_NO_ROW);

  `CPRM_ASSERT_NOW(a_stall_needs_full_input, in_stall_o, s1_valid_q && s2_valid_q)
  `CPRM_ASSERT_NEXT(a_advance_fills_result, s1_adv, out_valid_o)
  `CPRM_ASSERT_NEXT(a_toggle_holds_when_idle, !s1_adv, $stable(toggle_q))
  `CPRM_ASSERT_NEXT(a_keyboard_keeps_toggles, kbd_pending, $stable(toggle_q))

endmodule

FILE: bench/tb_controller_port_read_mux_top.sv
module tb_controller_port_read_mux_top;
  import cprm_pkg::*;

  localparam int RANDOM_READS = 1325;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    cfg_t      setup;
    read_req_t req;
    bit        typed;
    logic [7:0] want;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [2:0]  row_select_i = '0;
  logic [15:0] keyboard_word_i = '0;
  logic [15:0] pad_word_i = '0;
  logic [7:0]  port_control_i = '0;
  logic [7:0]  sportpad1_value_i = '0;
  logic [7:0]  sportpad2_value_i = '0;
  logic [7:0]  paddle1_position_i = '0;
  logic [7:0]  paddle2_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [2:0]  cfg_data_i = '0;

  logic [2:0] dev1_model = DEV_JOYPAD;
  logic [2:0] dev2_model = DEV_JOYPAD;
  logic       kbd_model = 1'b0;
  logic       paddle_strobe1 = 1'b0;
  logic       paddle_strobe2 = 1'b0;
  cfg_t       live_setup = '0;

  logic [7:0] pending_reads[$];
  probe_t     probes[$];
  int         fault_count = 0;
  int         send_level = 0;

  controller_port_read_mux_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .row_select_i       (row_select_i),
    .keyboard_word_i    (keyboard_word_i),
    .pad_word_i         (pad_word_i),
    .port_control_i     (port_control_i),
    .sportpad1_value_i  (sportpad1_value_i),
    .sportpad2_value_i  (sportpad2_value_i),
    .paddle1_position_i (paddle1_position_i),
    .paddle2_position_i (paddle2_position_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic analog_dev(input logic [2:0] dev);
    return (dev == DEV_PADDLE) || (dev == DEV_SPORTPAD);
  endfunction

  function automatic logic [7:0] predict_read_data(input read_req_t r);
    logic [7:0] v;
    logic [7:0] lo;
    logic [7:0] hi;
    if (kbd_model && r.row_select != KBD_NO_ROW) begin
      return r.mode ? r.keyboard_word[15:8] : r.keyboard_word[7:0];
    end
    if (!r.mode) begin
      v = r.pad_word[7:0];
      lo = {r.paddle2_position[1:0], 2'b01, r.paddle1_position[3:0]};
      hi = {r.paddle2_position[5:4], 2'b01, r.paddle1_position[7:4]};
      if (analog_dev(dev1_model) || analog_dev(dev2_model)) begin
        case (r.port_control)
          CTL_SP1_HIGH:    v = {v[7:4], r.sportpad1_value[7:4]};
          CTL_SP1_LOW:     v = {v[7:4], r.sportpad1_value[3:0]};
          CTL_SP2_UPPER:   v = {r.sportpad2_value[5:4], v[5:0]};
          CTL_SP2_LOWER:   v = {r.sportpad2_value[1:0], v[5:0]};
          CTL_FLIP_FLOP:   v = v & (paddle_strobe1 ? lo : hi);
          CTL_PADDLE_LOW:  v = v & lo;
          CTL_PADDLE_HIGH: v = v & hi;
          default: ;
        endcase
      end
      if (dev1_model == DEV_PADDLE) begin
        paddle_strobe1 = ~paddle_strobe1;
        v[5] = paddle_strobe1;
      end
    end else begin
      v = r.pad_word[15:8];
      lo = {6'b111111, r.paddle2_position[3:2]};
      hi = {6'b111111, r.paddle2_position[7:6]};
      if (analog_dev(dev2_model)) begin
        case (r.port_control)
          CTL_SP2_UPPER:   v = {v[7:2], r.sportpad2_value[7:6]};
          CTL_SP2_LOWER:   v = {v[7:2], r.sportpad2_value[3:2]};
          CTL_FLIP_FLOP:   v = v & (paddle_strobe2 ? lo : hi);
          CTL_PADDLE_LOW:  v = v & lo;
          CTL_PADDLE_HIGH: v = v & hi;
          default: ;
        endcase
      end
      if (dev2_model == DEV_PADDLE) begin
        paddle_strobe2 = ~paddle_strobe2;
        v[3] = paddle_strobe2;
      end
    end
    return v;
  endfunction

  function automatic int pick_idle(input int level);
    int roll;
    roll = $urandom_range(99);
    if (level == 0 || roll < (level == 1 ? 75 : 35)) begin
      return 0;
    end
    return (roll < 94) ? $urandom_range(3, 1) : $urandom_range(40, 8);
  endfunction

  function automatic read_req_t rq(input logic mode, input logic [2:0] row,
                                   input logic [15:0] kbw, input logic [15:0] pad,
                                   input logic [7:0] ctl, input logic [7:0] sp1,
                                   input logic [7:0] sp2, input logic [7:0] pd1,
                                   input logic [7:0] pd2);
    read_req_t r;
    r.mode = mode;
    r.row_select = row;
    r.keyboard_word = kbw;
    r.pad_word = pad;
    r.port_control = ctl;
    r.sportpad1_value = sp1;
    r.sportpad2_value = sp2;
    r.paddle1_position = pd1;
    r.paddle2_position = pd2;
    return r;
  endfunction

  function automatic cfg_t cf(input logic [2:0] p1, input logic [2:0] p2, input logic kb);
    cfg_t c;
    c.player1_device = p1;
    c.player2_device = p2;
    c.kbd_attached = kb;
    return c;
  endfunction

  function automatic logic [2:0] rand_device();
    case ($urandom_range(9))
      0, 1, 2: return DEV_PADDLE;
      3, 4, 5: return DEV_SPORTPAD;
      6:       return DEV_JOYPAD;
      7:       return DEV_TABLET;
      default: return 3'($urandom_range(7));
    endcase
  endfunction

  function automatic read_req_t rand_read(input logic kbd);
    read_req_t r;
    logic [7:0] ctl;
    case ($urandom_range(9))
      0:       ctl = CTL_SP1_HIGH;
      1:       ctl = CTL_SP1_LOW;
      2:       ctl = CTL_SP2_UPPER;
      3:       ctl = CTL_SP2_LOWER;
      4:       ctl = CTL_FLIP_FLOP;
      5:       ctl = CTL_PADDLE_LOW;
      6:       ctl = CTL_PADDLE_HIGH;
      default: ctl = 8'($urandom);
    endcase
    r = rq(1'($urandom), 3'($urandom), 16'($urandom), 16'($urandom), ctl,
           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if (kbd && $urandom_range(1) == 0) begin
      r.row_select = KBD_NO_ROW;
    end
    return r;
  endfunction

  task automatic add_probe(input cfg_t c, input read_req_t r, input bit typed,
                           input logic [7:0] want);
    probe_t p;
    p.setup = c;
    p.req = r;
    p.typed = typed;
    p.want = want;
    probes.push_back(p);
  endtask

  task automatic note_fault(input string what, input logic [7:0] want,
                            input logic [7:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic issue_read(input read_req_t r, input bit typed, input logic [7:0] want);
    int gap;
    logic [7:0] pred;
    gap = pick_idle(send_level);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    row_select_i <= r.row_select;
    keyboard_word_i <= r.keyboard_word;
    pad_word_i <= r.pad_word;
    port_control_i <= r.port_control;
    sportpad1_value_i <= r.sportpad1_value;
    sportpad2_value_i <= r.sportpad2_value;
    paddle1_position_i <= r.paddle1_position;
    paddle2_position_i <= r.paddle2_position;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_read_data(r);
    pending_reads.push_back(typed ? want : pred);
  endtask

  task automatic drain_reads();
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_setup(input cfg_t c);
    logic [1:0] idx[3];
    logic [2:0] val[3];
    idx = '{REG_PLAYER1_DEVICE, REG_PLAYER2_DEVICE, REG_KBD_ATTACHED};
    val = '{c.player1_device, c.player2_device, {2'b00, c.kbd_attached}};
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[k])
        REG_PLAYER1_DEVICE: dev1_model = val[k];
        REG_PLAYER2_DEVICE: dev2_model = val[k];
        REG_KBD_ATTACHED:   kbd_model = val[k][0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    live_setup = c;
  endtask

  always @(posedge clk_i) begin : stall_gen
    int hold;
    int level;
    int level_left;
    if (hold != 0) begin
      hold--;
    end else begin
      hold = pick_idle(level);
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        hold--;
      end
    end
    if (level_left == 0) begin
      level = $urandom_range(2);
      level_left = $urandom_range(300, 50);
    end else begin
      level_left--;
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        note_fault("unexpected read_data transaction", 8'h00, read_data_o);
      end else begin
        want = pending_reads.pop_front();
        if (read_data_o !== want) begin
          note_fault("read_data mismatch", want, read_data_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_t      c0, kb, sp, pd, hi, mix, odd, pick;
    int        sent;
    int        phase_len;

    c0 = cf(DEV_JOYPAD, DEV_JOYPAD, 1'b0);
    kb = cf(DEV_JOYPAD, DEV_JOYPAD, 1'b1);
    sp = cf(DEV_SPORTPAD, DEV_SPORTPAD, 1'b0);
    pd = cf(DEV_PADDLE, DEV_PADDLE, 1'b0);
    hi = cf(3'd7, 3'd7, 1'b0);
    mix = cf(DEV_JOYPAD, DEV_PADDLE, 1'b0);
    odd = cf(DEV_GUN, DEV_TABLET, 1'b0);

    add_probe(c0, rq(1'b0, KBD_NO_ROW, 16'hFFFF, 16'hA55A, CTL_SP1_HIGH,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 8'h5A);
    add_probe(c0, rq(1'b1, 3'd0, 16'h0000, 16'hA55A, CTL_FLIP_FLOP,
                     8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'hA5);
    add_probe(kb, rq(1'b0, 3'd0, 16'h1234, 16'h0000, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'h34);
    add_probe(kb, rq(1'b1, 3'd6, 16'hFFFF, 16'h0000, CTL_SP2_UPPER,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 8'hFF);
    add_probe(kb, rq(1'b0, KBD_NO_ROW, 16'h0000, 16'h00FF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'hFF);
    add_probe(kb, rq(1'b1, 3'd3, 16'h0000, 16'hFFFF, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 8'h00);
    add_probe(sp, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_SP1_HIGH,
                     8'hA5, 8'h96, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b0, 3'd0, 16'h0000, 16'h0000, CTL_SP1_LOW,
                     8'hA5, 8'h96, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_SP2_UPPER,
                     8'hA5, 8'h96, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b0, 3'd0, 16'h0000, 16'h0000, CTL_SP2_LOWER,
                     8'hA5, 8'hFF, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b1, 3'd0, 16'h0000, 16'hFF00, CTL_SP2_UPPER,
                     8'hA5, 8'h96, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b1, 3'd0, 16'h0000, 16'h0000, CTL_SP2_LOWER,
                     8'hA5, 8'h96, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(sp, rq(1'b1, 3'd0, 16'h0000, 16'h5A00, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, 8'h5A);
    add_probe(pd, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_FLIP_FLOP,
                     8'h00, 8'h00, 8'hC3, 8'h3C), 1'b0, 8'h00);
    add_probe(pd, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_FLIP_FLOP,
                     8'h00, 8'h00, 8'hC3, 8'h3C), 1'b0, 8'h00);
    add_probe(pd, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_PADDLE_LOW,
                     8'h00, 8'h00, 8'hFF, 8'hFF), 1'b0, 8'h00);
    add_probe(pd, rq(1'b0, 3'd0, 16'h0000, 16'h00DF, CTL_PADDLE_HIGH,
                     8'h00, 8'h00, 8'h5A, 8'hA5), 1'b0, 8'h00);
    add_probe(pd, rq(1'b1, 3'd0, 16'h0000, 16'hFF00, CTL_FLIP_FLOP,
                     8'h00, 8'h00, 8'h00, 8'hC3), 1'b0, 8'h00);
    add_probe(pd, rq(1'b1, 3'd0, 16'h0000, 16'hF700, CTL_FLIP_FLOP,
                     8'h00, 8'h00, 8'h00, 8'h3C), 1'b0, 8'h00);
    add_probe(pd, rq(1'b1, 3'd0, 16'h0000, 16'hFF00, CTL_PADDLE_LOW,
                     8'h00, 8'h00, 8'h00, 8'h0C), 1'b0, 8'h00);
    add_probe(pd, rq(1'b1, 3'd0, 16'h0000, 16'hFF00, CTL_PADDLE_HIGH,
                     8'h00, 8'h00, 8'h00, 8'h80), 1'b0, 8'h00);
    add_probe(hi, rq(1'b0, 3'd0, 16'h0000, 16'hFFFF, CTL_SP1_HIGH,
                     8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'hFF);
    add_probe(hi, rq(1'b1, 3'd0, 16'h0000, 16'hFFFF, CTL_SP2_UPPER,
                     8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'hFF);
    add_probe(mix, rq(1'b0, 3'd0, 16'h0000, 16'h00FF, CTL_SP2_UPPER,
                      8'h00, 8'hCF, 8'h00, 8'h00), 1'b0, 8'h00);
    add_probe(odd, rq(1'b0, 3'd0, 16'h0000, 16'h1234, CTL_PADDLE_LOW,
                      8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 8'h34);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].setup != live_setup) begin
        drain_reads();
        load_setup(probes[i].setup);
        send_level = $urandom_range(2);
      end
      issue_read(probes[i].req, probes[i].typed, probes[i].want);
    end

    sent = 0;
    while (sent < RANDOM_READS) begin
      drain_reads();
      pick = cf(rand_device(), rand_device(), $urandom_range(3) == 0);
      load_setup(pick);
      send_level = $urandom_range(2);
      phase_len = $urandom_range(150, 40);
      for (int k = 0; k < phase_len && sent < RANDOM_READS; k++) begin
        issue_read(rand_read(pick.kbd_attached), 1'b0, 8'h00);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
